/* hdl/vdc_pkg.sv */
// Shared types and constants for the video DMA controller.
`default_nettype none

package vdc_pkg;

  localparam int unsigned VRAM_BANK_BYTES_DEF = 8192;
  localparam int unsigned OAM_BYTES_DEF       = 160;
  localparam int unsigned BLOCK_LOG2          = 4;   // 16-byte blocks
  localparam int unsigned CYC_PER_BLOCK       = 32;
  localparam int unsigned OAM_TOTAL_CYC       = 648;
  localparam logic [7:0]  OAM_PAGE_MAX        = 8'hdf;
  localparam logic [7:0]  PTR_LOW_MASK        = 8'hf0;
  localparam logic [4:0]  DST_HIGH_MASK       = 5'h1f;
  localparam int unsigned RSP_DEPTH           = 4;

  typedef enum logic [2:0] {
    NDMA_IDLE     = 3'd0,
    NDMA_GEN_BUSY = 3'd1,
    NDMA_HB_WAIT  = 3'd2,
    NDMA_HB_BUSY  = 3'd3,
    NDMA_HB_DONE  = 3'd4
  } ndma_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_OAM_PAGE = 3'd0,
    REG_SRC_HI   = 3'd1,
    REG_SRC_LO   = 3'd2,
    REG_DST_HI   = 3'd3,
    REG_DST_LO   = 3'd4,
    REG_CONTROL  = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_select;
    logic [7:0] write_value;
    logic [7:0] cycles;
    logic       cpu_running;
    logic       double_speed;
    logic       in_hblank;
    logic       lcd_on;
  } req_t;

  typedef struct packed {
    logic        copy_valid;
    logic        copy_to_oam;
    logic [15:0] copy_source;
    logic [12:0] copy_dest;
    logic [11:0] copy_length;
    logic [7:0]  read_data;
    logic [2:0]  ndma_state;
    logic        oam_dma_busy;
    logic        last;
  } rsp_t;

  // Results produced by one request: count, then up to two entries in order.
  typedef struct packed {
    logic [1:0] num;
    rsp_t       r0;
    rsp_t       r1;
  } push_t;

endpackage

`default_nettype wire

/* hdl/vdc_intf.sv */
// Request and result channel interfaces of the video DMA controller.
`default_nettype none

interface vdc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] reg_select;
  logic [7:0] write_value;
  logic [7:0] cycles;
  logic       cpu_running;
  logic       double_speed;
  logic       in_hblank;
  logic       lcd_on;

  modport source (
    output valid, kind, reg_select, write_value, cycles, cpu_running, double_speed,
           in_hblank, lcd_on,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_select, write_value, cycles, cpu_running, double_speed,
           in_hblank, lcd_on,
    output ready
  );
endinterface

interface vdc_rsp_if;
  logic        valid;
  logic        ready;
  logic        copy_valid;
  logic        copy_to_oam;
  logic [15:0] copy_source;
  logic [12:0] copy_dest;
  logic [11:0] copy_length;
  logic [7:0]  read_data;
  logic [2:0]  ndma_state;
  logic        oam_dma_busy;
  logic        last;

  modport source (
    output valid, copy_valid, copy_to_oam, copy_source, copy_dest, copy_length,
           read_data, ndma_state, oam_dma_busy, last,
    input  ready
  );
  modport sink (
    input  valid, copy_valid, copy_to_oam, copy_source, copy_dest, copy_length,
           read_data, ndma_state, oam_dma_busy, last,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/vdc_core.sv */
// Request register, DMA state and single-pass update logic.
`default_nettype none

module vdc_core
  import vdc_pkg::*;
#(
  parameter int unsigned VRAM_BANK_BYTES = VRAM_BANK_BYTES_DEF,
  parameter int unsigned OAM_BYTES       = OAM_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_data_i,
  input  logic  room_i,
  output push_t push_o
);

  logic        valid_q, valid_d;
  req_t        data_q;
  logic        go;

  logic        color_mode_q;
  ndma_e       mode_q, mode_d, mode_h;
  logic        oam_active_q, oam_active_d;
  logic [7:0]  oam_page_q, oam_page_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [7:0]  blocks_q, blocks_d;
  logic [12:0] gcd_q, gcd_d;
  logic [5:0]  bcd_q, bcd_d, bcd_h;
  logic [9:0]  ocd_q, ocd_d;

  logic [7:0]  cyc_s;
  logic [5:0]  r4;
  logic [7:0]  run_n;
  logic [11:0] run_total;
  logic [7:0]  blocks_after;
  logic        in_bank;
  logic [16:0] room;
  logic [11:0] vram_len;
  logic        run_en, oam_hit, vram_hit;
  logic [7:0]  rd;
  logic [7:0]  blocks_new;
  logic        hb_mode_q;
  rsp_t        vram_desc, oam_desc, status;

  assign go         = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (go) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  // Shared terms of the request held in the input register
  assign cyc_s     = data_q.double_speed ? {1'b0, data_q.cycles[7:1]} : data_q.cycles;
  assign r4        = data_q.double_speed ? 6'd2 : 6'd4;
  assign hb_mode_q = (mode_q == NDMA_HB_WAIT) || (mode_q == NDMA_HB_BUSY) ||
                     (mode_q == NDMA_HB_DONE);
  assign blocks_new = {1'b0, data_q.write_value[6:0]} + 8'd1;

  // Block run: general DMA takes all blocks left, HBlank DMA one at most
  assign run_n        = (mode_q == NDMA_GEN_BUSY) ? blocks_q :
                        ((blocks_q != 8'd0) ? 8'd1 : 8'd0);
  assign run_total    = 12'(run_n) << BLOCK_LOG2;
  assign blocks_after = blocks_q - run_n;
  assign in_bank      = 17'(dst_q) < 17'(VRAM_BANK_BYTES);
  assign room         = 17'(VRAM_BANK_BYTES) - 17'(dst_q);
  assign vram_len     = (17'(run_total) < room) ? run_total : room[11:0];

  always_comb begin
    mode_d       = mode_q;
    mode_h       = mode_q;
    oam_active_d = oam_active_q;
    oam_page_d   = oam_page_q;
    src_d        = src_q;
    dst_d        = dst_q;
    blocks_d     = blocks_q;
    gcd_d        = gcd_q;
    bcd_d        = bcd_q;
    bcd_h        = bcd_q;
    ocd_d        = ocd_q;
    run_en       = 1'b0;
    oam_hit      = 1'b0;
    rd           = 8'd0;
    if (go) begin
      case (kind_e'(data_q.kind))
        KIND_TICK: begin
          if (data_q.cpu_running) begin
            if (mode_q == NDMA_GEN_BUSY) begin
              if (13'(cyc_s) >= gcd_q) begin
                run_en = 1'b1;
                mode_d = NDMA_IDLE;
                gcd_d  = 13'd0;
              end else begin
                gcd_d = gcd_q - 13'(cyc_s);
              end
            end
            if (hb_mode_q) begin
              if (mode_q == NDMA_HB_WAIT && data_q.in_hblank && data_q.lcd_on) begin
                bcd_h  = 6'(CYC_PER_BLOCK) + r4;
                mode_h = NDMA_HB_BUSY;
              end else if (mode_q == NDMA_HB_DONE && !data_q.in_hblank) begin
                mode_h = NDMA_HB_WAIT;
              end
              mode_d = mode_h;
              bcd_d  = bcd_h;
              if (mode_h == NDMA_HB_BUSY) begin
                if (cyc_s >= 8'(bcd_h)) begin
                  run_en = 1'b1;
                  mode_d = (blocks_after == 8'd0) ? NDMA_IDLE : NDMA_HB_DONE;
                  bcd_d  = 6'd0;
                end else begin
                  bcd_d = bcd_h - cyc_s[5:0];
                end
              end
            end
            if (oam_active_q) begin
              if (10'(data_q.cycles) >= ocd_q) begin
                oam_hit      = 1'b1;
                oam_active_d = 1'b0;
                ocd_d        = 10'd0;
              end else begin
                ocd_d = ocd_q - 10'(data_q.cycles);
              end
            end
          end
        end
        KIND_WRITE: begin
          case (reg_e'(data_q.reg_select))
            REG_OAM_PAGE: begin
              if (data_q.write_value <= OAM_PAGE_MAX) begin
                oam_page_d   = data_q.write_value;
                ocd_d        = 10'(OAM_TOTAL_CYC);
                oam_active_d = 1'b1;
              end
            end
            REG_SRC_HI: src_d = {data_q.write_value, src_q[7:0]};
            REG_SRC_LO: src_d = {src_q[15:8], data_q.write_value & PTR_LOW_MASK};
            REG_DST_HI: dst_d = {3'd0, data_q.write_value[4:0] & DST_HIGH_MASK, dst_q[7:0]};
            REG_DST_LO: dst_d = {dst_q[15:8], data_q.write_value & PTR_LOW_MASK};
            REG_CONTROL: begin
              if (color_mode_q) begin
                if (hb_mode_q && !data_q.write_value[7]) begin
                  // cancel a running HBlank transfer
                  mode_d = NDMA_IDLE;
                end else begin
                  blocks_d = blocks_new;
                  if (data_q.write_value[7]) begin
                    mode_d = NDMA_HB_WAIT;
                  end else begin
                    gcd_d  = 13'(CYC_PER_BLOCK) * 13'(blocks_new) + 13'(r4);
                    mode_d = NDMA_GEN_BUSY;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        KIND_READ: begin
          if (reg_e'(data_q.reg_select) == REG_OAM_PAGE) begin
            rd = oam_page_q;
          end else if (reg_e'(data_q.reg_select) == REG_CONTROL) begin
            rd = {(mode_q == NDMA_IDLE), 7'(blocks_q - 8'd1)};
          end
        end
        default: ;
      endcase
      if (run_en) begin
        src_d    = src_q + 16'(run_total);
        dst_d    = dst_q + 16'(run_total);
        blocks_d = blocks_after;
      end
    end
  end

  assign vram_hit = run_en && in_bank && (vram_len != 12'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      mode_q       <= NDMA_IDLE;
      oam_active_q <= 1'b0;
      oam_page_q   <= 8'd0;
      src_q        <= 16'd0;
      dst_q        <= 16'd0;
      blocks_q     <= 8'd0;
      gcd_q        <= 13'd0;
      bcd_q        <= 6'd0;
      ocd_q        <= 10'd0;
    end else begin
      if (cfg_we_i) begin
        color_mode_q <= cfg_wdata_i;
      end
      mode_q       <= mode_d;
      oam_active_q <= oam_active_d;
      oam_page_q   <= oam_page_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      blocks_q     <= blocks_d;
      gcd_q        <= gcd_d;
      bcd_q        <= bcd_d;
      ocd_q        <= ocd_d;
    end
  end

  always_comb begin
    status              = '0;
    status.read_data    = rd;
    status.ndma_state   = mode_d;
    status.oam_dma_busy = oam_active_d;
    status.last         = 1'b1;

    vram_desc             = status;
    vram_desc.copy_valid  = 1'b1;
    vram_desc.copy_to_oam = 1'b0;
    vram_desc.copy_source = src_q;
    vram_desc.copy_dest   = dst_q[12:0];
    vram_desc.copy_length = vram_len;
    vram_desc.last        = !oam_hit;

    oam_desc             = status;
    oam_desc.copy_valid  = 1'b1;
    oam_desc.copy_to_oam = 1'b1;
    oam_desc.copy_source = {oam_page_q, 8'd0};
    oam_desc.copy_dest   = 13'd0;
    oam_desc.copy_length = 12'(OAM_BYTES);

    push_o.r1 = oam_desc;
    if (vram_hit) begin
      push_o.r0 = vram_desc;
    end else if (oam_hit) begin
      push_o.r0 = oam_desc;
    end else begin
      push_o.r0 = status;
    end
    if (!go) begin
      push_o.num = 2'd0;
    end else if (vram_hit && oam_hit) begin
      push_o.num = 2'd2;
    end else begin
      push_o.num = 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hdl/vdc_rsp_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module vdc_rsp_fifo
  import vdc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rsp_t  out_data_o
);

  localparam int unsigned PtrW = $clog2(RSP_DEPTH);

  rsp_t            mem_q [RSP_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // keep space for a two-result request
  assign room_o      = cnt_q <= (PtrW + 1)'(RSP_DEPTH - 2);

  assign wr_d  = wr_q + PtrW'(push_i.num);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + (PtrW + 1)'(push_i.num) - (PtrW + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/video_dma_controller_unit.sv */
// Video DMA controller: general, HBlank and sprite-table DMA timing with copy descriptors.
//
// Requests arrive on req_i (valid/ready): a tick carrying elapsed cycles, a register
// write or a register read. Each request gives one result on rsp_o, or two when a tick
// finishes both a video RAM transfer and a sprite-table transfer; the video RAM
// descriptor comes first and the final result of a request has last set.
// cfg_we_i/cfg_wdata_i write color_mode, which enables the control register.
// An accepted request is held in the request register; once the queue has room it is
// processed and its results are written into the result queue that drives rsp_o.
// Throughput: one request per cycle while each yields one result and rsp_o is taken
// every cycle; a two-result tick needs the single result port for each of its results.
// The rate is set by the one read port of the four-entry result queue.
// req_i.ready drops only while the request register holds an item and the queue has
// no room for two more results; a stalled receiver fills the queue and then backs up
// into the request register, and nothing is lost or repeated.
// Reset clears all pointers, counters and DMA state to idle and empties the queue;
// a request is taken as soon as reset is released, as req_i.ready is high while empty.
`default_nettype none

module video_dma_controller_unit
  import vdc_pkg::*;
#(
  parameter int unsigned VRAM_BANK_BYTES = VRAM_BANK_BYTES_DEF,
  parameter int unsigned OAM_BYTES       = OAM_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  vdc_req_if.sink          req_i,
  vdc_rsp_if.source        rsp_o
);

  req_t  req;
  rsp_t  rsp;
  push_t push;
  logic  room;

  assign req.kind         = req_i.kind;
  assign req.reg_select   = req_i.reg_select;
  assign req.write_value  = req_i.write_value;
  assign req.cycles       = req_i.cycles;
  assign req.cpu_running  = req_i.cpu_running;
  assign req.double_speed = req_i.double_speed;
  assign req.in_hblank    = req_i.in_hblank;
  assign req.lcd_on       = req_i.lcd_on;

  vdc_core #(
    .VRAM_BANK_BYTES(VRAM_BANK_BYTES),
    .OAM_BYTES      (OAM_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .in_data_i  (req),
    .room_i     (room),
    .push_o     (push)
  );

  vdc_rsp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .out_data_o (rsp)
  );

  assign rsp_o.copy_valid   = rsp.copy_valid;
  assign rsp_o.copy_to_oam  = rsp.copy_to_oam;
  assign rsp_o.copy_source  = rsp.copy_source;
  assign rsp_o.copy_dest    = rsp.copy_dest;
  assign rsp_o.copy_length  = rsp.copy_length;
  assign rsp_o.read_data    = rsp.read_data;
  assign rsp_o.ndma_state   = rsp.ndma_state;
  assign rsp_o.oam_dma_busy = rsp.oam_dma_busy;
  assign rsp_o.last         = rsp.last;

endmodule

`default_nettype wire

/* hdl/vdc_checker.sv */
// Port-level assertions for the video DMA controller and their bind.
`default_nettype none

module vdc_checker
  import vdc_pkg::*;
#(
  parameter int unsigned OAM_BYTES = OAM_BYTES_DEF
) (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        rsp_valid_i,
  input wire        rsp_ready_i,
  input wire        copy_valid_i,
  input wire        copy_to_oam_i,
  input wire [15:0] copy_source_i,
  input wire [12:0] copy_dest_i,
  input wire [11:0] copy_length_i,
  input wire        last_i
);

  // result channel must hold a pending result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_i)
    else $error("result shown during reset");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !copy_valid_i |-> !copy_to_oam_i && copy_source_i == 16'd0 &&
      copy_dest_i == 13'd0 && copy_length_i == 12'd0 && last_i)
    else $error("status result carries descriptor data");

  a_oam_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && copy_valid_i && copy_to_oam_i |->
      copy_source_i[7:0] == 8'd0 && copy_dest_i == 13'd0 &&
      copy_length_i == 12'(OAM_BYTES) && last_i)
    else $error("malformed sprite descriptor");

  a_first_is_vram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !last_i |-> copy_valid_i && !copy_to_oam_i)
    else $error("non-final result is not a video RAM descriptor");

endmodule

bind video_dma_controller_unit vdc_checker #(
  .OAM_BYTES(OAM_BYTES)
) u_vdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .copy_valid_i (rsp_o.copy_valid),
  .copy_to_oam_i(rsp_o.copy_to_oam),
  .copy_source_i(rsp_o.copy_source),
  .copy_dest_i  (rsp_o.copy_dest),
  .copy_length_i(rsp_o.copy_length),
  .last_i       (rsp_o.last)
);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the video DMA controller: predicts and checks every result.
module tb;
  import vdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  // Tracks the DMA state of the block and the results each request must produce.
  class dma_ledger;
    logic        color_mode;
    ndma_e       dma_mode;
    logic        oam_busy;
    logic [7:0]  oam_page;
    logic [15:0] src_ptr;
    logic [15:0] dst_ptr;
    logic [7:0]  blocks_left;
    logic [12:0] gen_wait;
    logic [5:0]  blk_wait;
    logic [9:0]  oam_wait;
    rsp_t        copies[$];
    rsp_t        pending_results[$];
    int unsigned fails;
    int unsigned reported;

    function new();
      color_mode  = 1'b0;
      dma_mode    = NDMA_IDLE;
      oam_busy    = 1'b0;
      oam_page    = '0;
      src_ptr     = '0;
      dst_ptr     = '0;
      blocks_left = '0;
      gen_wait    = '0;
      blk_wait    = '0;
      oam_wait    = '0;
      fails       = 0;
      reported    = 0;
    endfunction

    function bit hblank_on();
      return dma_mode == NDMA_HB_WAIT || dma_mode == NDMA_HB_BUSY ||
             dma_mode == NDMA_HB_DONE;
    endfunction

    // Emit a video RAM copy for up to max_blocks, clipped at the bank end.
    function void copy_blocks(logic [7:0] max_blocks);
      logic [7:0]  n;
      int unsigned total;
      int unsigned span;
      int unsigned room;
      rsp_t d;
      n     = (max_blocks < blocks_left) ? max_blocks : blocks_left;
      total = 32'(n) << BLOCK_LOG2;
      span  = 0;
      if (32'(dst_ptr) < VRAM_BANK_BYTES_DEF) begin
        room = VRAM_BANK_BYTES_DEF - 32'(dst_ptr);
        span = (total < room) ? total : room;
      end
      if (span > 0 && copies.size() < 2) begin
        d             = '0;
        d.copy_valid  = 1'b1;
        d.copy_source = src_ptr;
        d.copy_dest   = dst_ptr[12:0];
        d.copy_length = 12'(span);
        copies.push_back(d);
      end
      src_ptr     = src_ptr + 16'(total);
      dst_ptr     = dst_ptr + 16'(total);
      blocks_left = blocks_left - n;
    endfunction

    function void write_control(logic [7:0] val, logic ds);
      int unsigned span;
      if (!color_mode) return;
      if (hblank_on() && !val[7]) begin
        dma_mode = NDMA_IDLE;
        return;
      end
      blocks_left = {1'b0, val[6:0]} + 8'd1;
      if (val[7]) begin
        dma_mode = NDMA_HB_WAIT;
      end else begin
        span     = CYC_PER_BLOCK * 32'(blocks_left) + (ds ? 2 : 4);
        gen_wait = 13'(span);
        dma_mode = NDMA_GEN_BUSY;
      end
    endfunction

    function void advance_time(logic [7:0] cyc, logic ds, logic hb, logic lcd);
      logic [7:0] c;
      rsp_t d;
      c = ds ? (cyc >> 1) : cyc;
      if (dma_mode == NDMA_GEN_BUSY) begin
        if (13'(c) >= gen_wait) begin
          copy_blocks(blocks_left);
          dma_mode = NDMA_IDLE;
          gen_wait = '0;
        end else begin
          gen_wait = gen_wait - 13'(c);
        end
      end
      if (hblank_on()) begin
        if (dma_mode == NDMA_HB_WAIT && hb && lcd) begin
          blk_wait = 6'(CYC_PER_BLOCK) + (ds ? 6'd2 : 6'd4);
          dma_mode = NDMA_HB_BUSY;
        end else if (dma_mode == NDMA_HB_DONE && !hb) begin
          dma_mode = NDMA_HB_WAIT;
        end
        if (dma_mode == NDMA_HB_BUSY) begin
          if (c >= 8'(blk_wait)) begin
            copy_blocks(8'd1);
            dma_mode = (blocks_left == 8'd0) ? NDMA_IDLE : NDMA_HB_DONE;
            blk_wait = '0;
          end else begin
            blk_wait = blk_wait - c[5:0];
          end
        end
      end
      // Sprite DMA runs on undivided cycles.
      if (oam_busy) begin
        if (10'(cyc) >= oam_wait) begin
          if (copies.size() < 2) begin
            d             = '0;
            d.copy_valid  = 1'b1;
            d.copy_to_oam = 1'b1;
            d.copy_source = {oam_page, 8'h00};
            d.copy_length = 12'(OAM_BYTES_DEF);
            copies.push_back(d);
          end
          oam_busy = 1'b0;
          oam_wait = '0;
        end else begin
          oam_wait = oam_wait - 10'(cyc);
        end
      end
    endfunction

    function void note_request(req_t r);
      logic [7:0] rd;
      logic [7:0] left;
      rsp_t d;
      copies.delete();
      rd = '0;
      case (r.kind)
        KIND_TICK: begin
          if (r.cpu_running) advance_time(r.cycles, r.double_speed, r.in_hblank, r.lcd_on);
        end
        KIND_WRITE: begin
          case (r.reg_select)
            REG_OAM_PAGE: begin
              if (r.write_value <= OAM_PAGE_MAX) begin
                oam_page = r.write_value;
                oam_wait = 10'(OAM_TOTAL_CYC);
                oam_busy = 1'b1;
              end
            end
            REG_SRC_HI:  src_ptr[15:8] = r.write_value;
            REG_SRC_LO:  src_ptr[7:0]  = r.write_value & PTR_LOW_MASK;
            REG_DST_HI:  dst_ptr[15:8] = {3'b000, r.write_value[4:0] & DST_HIGH_MASK};
            REG_DST_LO:  dst_ptr[7:0]  = r.write_value & PTR_LOW_MASK;
            REG_CONTROL: write_control(r.write_value, r.double_speed);
            default: ;
          endcase
        end
        KIND_READ: begin
          if (r.reg_select == REG_OAM_PAGE) begin
            rd = oam_page;
          end else if (r.reg_select == REG_CONTROL) begin
            left = blocks_left - 8'd1;
            rd   = {dma_mode == NDMA_IDLE, left[6:0]};
          end
        end
        default: ;
      endcase
      if (copies.size() == 0) copies.push_back('0);
      foreach (copies[k]) begin
        d              = copies[k];
        d.read_data    = rd;
        d.ndma_state   = dma_mode;
        d.oam_dma_busy = oam_busy;
        d.last         = (k == copies.size() - 1);
        pending_results.push_back(d);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      bit   bad;
      if (pending_results.size() == 0) begin
        fails++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("%0t: result with no request outstanding: %p", $time, got);
        end
        return;
      end
      want = pending_results.pop_front();
      bad  = got.copy_valid   !== want.copy_valid   ||
             got.copy_to_oam  !== want.copy_to_oam  ||
             got.copy_source  !== want.copy_source  ||
             got.copy_dest    !== want.copy_dest    ||
             got.copy_length  !== want.copy_length  ||
             got.read_data    !== want.read_data    ||
             got.ndma_state   !== want.ndma_state   ||
             got.oam_dma_busy !== want.oam_dma_busy ||
             got.last         !== want.last;
      if (bad) begin
        fails++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("%0t: mismatch", $time);
          $display("  expected v%b oam%b src %h dst %h len %0d rd %h st %0d busy %b last %b",
                   want.copy_valid, want.copy_to_oam, want.copy_source, want.copy_dest,
                   want.copy_length, want.read_data, want.ndma_state, want.oam_dma_busy,
                   want.last);
          $display("  actual   v%b oam%b src %h dst %h len %0d rd %h st %0d busy %b last %b",
                   got.copy_valid, got.copy_to_oam, got.copy_source, got.copy_dest,
                   got.copy_length, got.read_data, got.ndma_state, got.oam_dma_busy,
                   got.last);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  vdc_req_if req_bus ();
  vdc_rsp_if rsp_bus ();

  video_dma_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  dma_ledger   ledger;
  int unsigned burst_left;
  int unsigned sent;
  int unsigned cycle_count = 0;
  int unsigned rx_span = 0;
  int unsigned rx_style = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: alternate between always ready, coin-flip and mostly stalled.
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_span  = $urandom_range(20, 80);
    end
    rx_span--;
    case (rx_style)
      0:       rsp_bus.ready = 1'b1;
      1:       rsp_bus.ready = 1'($urandom_range(0, 1));
      default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : grab_result
    rsp_t got;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got.copy_valid   = rsp_bus.copy_valid;
      got.copy_to_oam  = rsp_bus.copy_to_oam;
      got.copy_source  = rsp_bus.copy_source;
      got.copy_dest    = rsp_bus.copy_dest;
      got.copy_length  = rsp_bus.copy_length;
      got.read_data    = rsp_bus.read_data;
      got.ndma_state   = rsp_bus.ndma_state;
      got.oam_dma_busy = rsp_bus.oam_dma_busy;
      got.last         = rsp_bus.last;
      ledger.check_result(got);
    end
  end

  // Offer one request, holding it until the block takes it; gaps fall between bursts.
  task automatic push_request(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_bus.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_bus.kind         = r.kind;
    req_bus.reg_select   = r.reg_select;
    req_bus.write_value  = r.write_value;
    req_bus.cycles       = r.cycles;
    req_bus.cpu_running  = r.cpu_running;
    req_bus.double_speed = r.double_speed;
    req_bus.in_hblank    = r.in_hblank;
    req_bus.lcd_on       = r.lcd_on;
    req_bus.valid        = 1'b1;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    ledger.note_request(r);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic reg_access(input logic [1:0] k, input logic [2:0] sel, input logic [7:0] val);
    req_t r;
    r             = req_t'($urandom);
    r.kind        = k;
    r.reg_select  = sel;
    r.write_value = val;
    push_request(r);
  endtask

  task automatic send_tick(input logic run, input logic [7:0] cyc, input logic ds,
                           input logic hb, input logic lcd);
    req_t r;
    r              = req_t'($urandom);
    r.kind         = KIND_TICK;
    r.cycles       = cyc;
    r.cpu_running  = run;
    r.double_speed = ds;
    r.in_hblank    = hb;
    r.lcd_on       = lcd;
    push_request(r);
  endtask

  task automatic random_tick(input logic hb);
    send_tick($urandom_range(0, 9) != 0,
              8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 255)),
              1'($urandom_range(0, 1)), hb, $urandom_range(0, 5) != 0);
  endtask

  task automatic load_pointers();
    reg_access(KIND_WRITE, REG_SRC_HI, 8'($urandom));
    reg_access(KIND_WRITE, REG_SRC_LO, 8'($urandom));
    // Favor the top of the bank so transfers run past its end.
    reg_access(KIND_WRITE, REG_DST_HI,
               ($urandom_range(0, 2) == 0) ? 8'h1f : 8'($urandom_range(0, 255)));
    reg_access(KIND_WRITE, REG_DST_LO, 8'($urandom));
  endtask

  // Hold requests until every outstanding result has come back, then let the block settle.
  task automatic drain();
    req_bus.valid = 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_color_mode(input logic v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    ledger.color_mode = v;
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned guard;
    req_t r;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // general DMA, sometimes with a sprite DMA racing it
          load_pointers();
          if ($urandom_range(0, 2) == 0)
            reg_access(KIND_WRITE, REG_OAM_PAGE, 8'($urandom_range(0, 8'hdf)));
          reg_access(KIND_WRITE, REG_CONTROL,
                     {1'b0, ($urandom_range(0, 9) == 0) ? 7'h7f : 7'($urandom_range(0, 7))});
          guard = 0;
          while (ledger.dma_mode == NDMA_GEN_BUSY && guard < 300) begin
            guard++;
            case ($urandom_range(0, 29))
              0:       reg_access(KIND_WRITE, REG_CONTROL, {1'b0, 7'($urandom_range(0, 7))});
              1:       reg_access(KIND_READ, REG_CONTROL, 8'($urandom));
              default: random_tick(1'($urandom_range(0, 1)));
            endcase
          end
        end
        3, 4, 5: begin
          // HBlank DMA
          load_pointers();
          if ($urandom_range(0, 2) == 0)
            reg_access(KIND_WRITE, REG_OAM_PAGE, 8'($urandom_range(0, 8'hdf)));
          reg_access(KIND_WRITE, REG_CONTROL, {1'b1, 7'($urandom_range(0, 7))});
          guard = 0;
          while (ledger.dma_mode != NDMA_IDLE && guard < 200) begin
            guard++;
            case ($urandom_range(0, 29))
              0:       reg_access(KIND_WRITE, REG_CONTROL, 8'($urandom));
              1:       reg_access(KIND_READ, REG_CONTROL, 8'($urandom));
              default: random_tick(1'($urandom_range(0, 1)));
            endcase
          end
        end
        6, 7: begin
          // sprite-table DMA, with an occasional page out of range
          reg_access(KIND_WRITE, REG_OAM_PAGE,
                     8'(($urandom_range(0, 4) == 0) ? $urandom_range(8'he0, 8'hff)
                                                     : $urandom_range(0, 8'hdf)));
          guard = 0;
          while (ledger.oam_busy && guard < 40) begin
            guard++;
            if ($urandom_range(0, 7) == 0) reg_access(KIND_READ, REG_OAM_PAGE, 8'($urandom));
            else random_tick(1'($urandom_range(0, 1)));
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            r = req_t'($urandom);
            push_request(r);
          end
          if ($urandom_range(0, 11) == 0) drain();
        end
      endcase
    end
  endtask

  initial begin
    ledger               = new();
    burst_left           = 0;
    sent                 = 0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.kind         = KIND_TICK;
    req_bus.reg_select   = REG_OAM_PAGE;
    req_bus.write_value  = '0;
    req_bus.cycles       = '0;
    req_bus.cpu_running  = 1'b0;
    req_bus.double_speed = 1'b0;
    req_bus.in_hblank    = 1'b0;
    req_bus.lcd_on       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    set_color_mode(1'b1);

    // reads out of reset, ignored writes, unused kind, stopped processor
    reg_access(KIND_READ, REG_CONTROL, 8'h00);
    reg_access(KIND_READ, REG_OAM_PAGE, 8'h00);
    reg_access(KIND_WRITE, REG_OAM_PAGE, 8'he0);
    reg_access(KIND_WRITE, REG_SPARE_LO, 8'hff);
    reg_access(KIND_SPARE, REG_SPARE_HI, 8'h5a);
    reg_access(KIND_WRITE, REG_OAM_PAGE, OAM_PAGE_MAX);
    send_tick(1'b0, 8'hff, 1'b0, 1'b1, 1'b1);
    // pointers at the very top: source wraps, destination clips at the bank end
    reg_access(KIND_WRITE, REG_SRC_HI, 8'hff);
    reg_access(KIND_WRITE, REG_SRC_LO, 8'hff);
    reg_access(KIND_WRITE, REG_DST_HI, 8'hff);
    reg_access(KIND_WRITE, REG_DST_LO, 8'hff);
    // general DMA restarted while busy
    reg_access(KIND_WRITE, REG_CONTROL, 8'h01);
    reg_access(KIND_WRITE, REG_CONTROL, 8'h03);
    reg_access(KIND_READ, REG_CONTROL, 8'h00);
    send_tick(1'b1, 8'hff, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 8'hff, 1'b1, 1'b0, 1'b0);
    // HBlank DMA: start, stop, start again beyond the bank end
    reg_access(KIND_WRITE, REG_CONTROL, 8'h80);
    reg_access(KIND_WRITE, REG_CONTROL, 8'h00);
    reg_access(KIND_WRITE, REG_CONTROL, 8'h81);
    send_tick(1'b1, 8'hff, 1'b0, 1'b1, 1'b1);
    reg_access(KIND_WRITE, REG_DST_HI, 8'h00);
    reg_access(KIND_WRITE, REG_DST_LO, 8'h00);
    send_tick(1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 8'hff, 1'b1, 1'b1, 1'b1);
    reg_access(KIND_READ, REG_CONTROL, 8'h00);
    drain();

    random_traffic(200);
    drain();
    set_color_mode(1'b0);
    random_traffic(290);
    drain();
    set_color_mode(1'b1);
    random_traffic(400);
    drain();
    repeat (8) @(posedge clk_i);

    if (ledger.fails == 0 && ledger.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/vdc_pkg.sv
hdl/vdc_intf.sv
hdl/vdc_core.sv
hdl/vdc_rsp_fifo.sv
hdl/video_dma_controller_unit.sv
hdl/vdc_checker.sv
bench/tb.sv
